### rtl/psma_pkg.sv
// Shared types and constants for the page state map allocator.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package psma_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned INC_W      = 23;
  localparam int unsigned HP_W       = 11;
  localparam int unsigned PAGE_IDX_W = 10;
  localparam int unsigned OFFSET_W   = 12;
  localparam int unsigned TOTAL_W    = INC_W + 1;

  localparam logic [HP_W-1:0] HEAP_PAGES_RST = 11'd1024;

  typedef enum logic [1:0] {
    PS_RESERVED = 2'd0,
    PS_FREE     = 2'd1,
    PS_PAGE     = 2'd2,
    PS_BREAK    = 2'd3
  } page_state_e;

  typedef enum logic [OP_W-1:0] {
    OP_REBUILD = 2'd0,
    OP_ALLOC   = 2'd1,
    OP_GROW    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RK_ZERO  = 2'd0,
    RK_FAIL  = 2'd1,
    RK_ALLOC = 2'd2,
    RK_GROW  = 2'd3
  } res_kind_e;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_BOOT_SWEEP,
    ST_IDLE,
    ST_SWEEP,
    ST_ALLOC,
    ST_GROW_PRE,
    ST_GROW_CHK,
    ST_GROW_WR,
    ST_NOP
  } ctrl_state_e;

  typedef struct packed {
    logic      rebuild_init;
    logic      sweep_step;
    logic      alloc_init;
    logic      alloc_step;
    logic      grow_init;
    logic      grow_pre;
    logic      chk_step;
    logic      wr_init;
    logic      wr_step;
    logic      finish;
    res_kind_e kind;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic hit;
    logic bad;
    logic scan_idle;
    logic pre_fail;
    logic wr_last;
  } dp_sts_t;

endpackage

### rtl/psma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module psma_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/psma_dp.sv
// Datapath of the page state map allocator: config register, break state, scan counters,
// page state memory and result registers. Depends on psma_pkg and psma_ram.
`timescale 1ns / 1ps

module psma_dp
  import psma_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dp_cmd_t               cmd_i,
  output dp_sts_t               sts_o,
  input  logic [INC_W-1:0]      increment_i,
  input  logic                  cfg_valid_i,
  input  logic [HP_W-1:0]       cfg_data_i,
  output logic                  done_o,
  output logic                  status_o,
  output logic [PAGE_IDX_W-1:0] page_index_o,
  output logic [OFFSET_W-1:0]   byte_offset_o
);

  localparam int unsigned AW  = $clog2(NUM_PAGES);
  localparam int unsigned ACW = AW + 1;
  localparam int unsigned PBL = $clog2(PAGE_BYTES);
  localparam int unsigned XW  = ((ACW > 16) ? ACW : 16) + 1;
  localparam int unsigned MW  = (ACW > HP_W) ? ACW : HP_W;

  logic [HP_W-1:0]       heap_pages_q, heap_pages_d;
  logic [ACW-1:0]        active_q, active_d;
  logic [ACW-1:0]        base_q, base_d;
  logic [INC_W-1:0]      break_q, break_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [XW-1:0]         first_q, first_d;
  logic [XW-1:0]         last_q, last_d;
  logic [XW-1:0]         scan_q, scan_d;
  logic                  scan_v_q, scan_v_d;
  logic                  pend_q, pend_d;
  logic [XW-1:0]         chk_q, chk_d;
  logic                  done_q, done_d;
  logic                  status_q, status_d;
  logic [PAGE_IDX_W-1:0] page_q, page_d;
  logic [OFFSET_W-1:0]   offset_q, offset_d;

  logic [MW-1:0]    hp_w, n_w;
  logic [ACW-1:0]   active_n;
  logic [XW-1:0]    info_w;
  logic [XW-1:0]    first_n, last_n;
  logic [INC_W-1:0] off_w;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [1:0]       ram_wdata;
  logic [1:0]       ram_rdata;

  // Clamp the page count to the supported range and size the reserved map area.
  always_comb begin
    hp_w = MW'(heap_pages_q);
    if (hp_w < MW'(2)) begin
      n_w = MW'(2);
    end else if (hp_w > MW'(NUM_PAGES)) begin
      n_w = MW'(NUM_PAGES);
    end else begin
      n_w = hp_w;
    end
    active_n = ACW'(n_w);
    info_w   = (XW'(active_n) + XW'(PAGE_BYTES - 1)) >> PBL;
  end

  assign first_n = XW'(base_q) + XW'(break_q >> PBL);
  assign last_n  = XW'(base_q) + XW'(total_q >> PBL);
  assign off_w   = INC_W'(break_q[PBL-1:0]);

  assign sts_o.sweep_last = (scan_q == XW'(NUM_PAGES - 1));
  assign sts_o.hit        = pend_q && (ram_rdata == PS_FREE);
  assign sts_o.bad        = pend_q && ((ram_rdata == PS_RESERVED) || (ram_rdata == PS_PAGE));
  assign sts_o.scan_idle  = !pend_q && !scan_v_q;
  assign sts_o.pre_fail   = total_q[TOTAL_W-1] || (last_n >= XW'(active_q));
  assign sts_o.wr_last    = (scan_q == last_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_q[AW-1:0];
    ram_wdata = PS_FREE;
    if (cmd_i.sweep_step) begin
      ram_we    = 1'b1;
      ram_wdata = (scan_q < XW'(base_q)) ? PS_RESERVED : PS_FREE;
    end else if (cmd_i.wr_step) begin
      ram_we    = 1'b1;
      ram_wdata = PS_BREAK;
    end else if (cmd_i.finish && (cmd_i.kind == RK_ALLOC)) begin
      ram_we    = 1'b1;
      ram_waddr = chk_q[AW-1:0];
      ram_wdata = PS_PAGE;
    end
  end

  always_comb begin
    heap_pages_d = heap_pages_q;
    active_d     = active_q;
    base_d       = base_q;
    break_d      = break_q;
    total_d      = total_q;
    first_d      = first_q;
    last_d       = last_q;
    scan_d       = scan_q;
    scan_v_d     = scan_v_q;
    pend_d       = pend_q;
    chk_d        = chk_q;
    done_d       = 1'b0;
    status_d     = status_q;
    page_d       = page_q;
    offset_d     = offset_q;

    if (cfg_valid_i) begin
      heap_pages_d = cfg_data_i;
    end

    if (cmd_i.rebuild_init) begin
      active_d = active_n;
      base_d   = ACW'(info_w);
      break_d  = '0;
      scan_d   = '0;
    end
    if (cmd_i.sweep_step || cmd_i.wr_step) begin
      scan_d = scan_q + XW'(1);
    end
    if (cmd_i.alloc_init) begin
      scan_d   = XW'(active_q) - XW'(1);
      scan_v_d = 1'b1;
      pend_d   = 1'b0;
    end
    if (cmd_i.alloc_step) begin
      pend_d   = scan_v_q;
      chk_d    = scan_q;
      scan_d   = scan_q - XW'(1);
      scan_v_d = scan_v_q && (scan_q != XW'(1));
    end
    if (cmd_i.grow_init) begin
      total_d = TOTAL_W'(break_q) + TOTAL_W'(increment_i);
      first_d = first_n;
      scan_d  = first_n;
      pend_d  = 1'b0;
    end
    if (cmd_i.grow_pre) begin
      last_d   = last_n;
      scan_v_d = 1'b1;
    end
    if (cmd_i.chk_step) begin
      pend_d   = scan_v_q;
      chk_d    = scan_q;
      scan_d   = scan_q + XW'(1);
      scan_v_d = scan_v_q && (scan_q != last_q);
    end
    if (cmd_i.wr_init) begin
      scan_d = first_q;
    end

    if (cmd_i.finish) begin
      done_d   = 1'b1;
      status_d = 1'b0;
      page_d   = '0;
      offset_d = '0;
      case (cmd_i.kind)
        RK_FAIL: begin
          status_d = 1'b1;
        end
        RK_ALLOC: begin
          page_d = chk_q[PAGE_IDX_W-1:0];
        end
        RK_GROW: begin
          page_d   = first_q[PAGE_IDX_W-1:0];
          offset_d = off_w[OFFSET_W-1:0];
          break_d  = total_q[INC_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_pages_q <= HEAP_PAGES_RST;
      active_q     <= '0;
      base_q       <= '0;
      break_q      <= '0;
      total_q      <= '0;
      first_q      <= '0;
      last_q       <= '0;
      scan_q       <= '0;
      scan_v_q     <= 1'b0;
      pend_q       <= 1'b0;
      chk_q        <= '0;
      done_q       <= 1'b0;
      status_q     <= 1'b0;
      page_q       <= '0;
      offset_q     <= '0;
    end else begin
      heap_pages_q <= heap_pages_d;
      active_q     <= active_d;
      base_q       <= base_d;
      break_q      <= break_d;
      total_q      <= total_d;
      first_q      <= first_d;
      last_q       <= last_d;
      scan_q       <= scan_d;
      scan_v_q     <= scan_v_d;
      pend_q       <= pend_d;
      chk_q        <= chk_d;
      done_q       <= done_d;
      status_q     <= status_d;
      page_q       <= page_d;
      offset_q     <= offset_d;
    end
  end

  psma_ram #(
    .WIDTH(2),
    .DEPTH(NUM_PAGES)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(scan_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign page_index_o  = page_q;
  assign byte_offset_o = offset_q;

endmodule

### rtl/psma_ctrl.sv
// Controller state machine of the page state map allocator.
// Depends on psma_pkg; drives datapath commands from datapath status.
`timescale 1ns / 1ps

module psma_ctrl
  import psma_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [OP_W-1:0] op_i,
  input  dp_sts_t         sts_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  ctrl_state_e state_q, state_d;
  op_e         op_w;

  assign op_w = op_e'(op_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_BOOT: begin
        state_d = ST_BOOT_SWEEP;
      end
      ST_BOOT_SWEEP: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_w)
            OP_REBUILD: state_d = ST_SWEEP;
            OP_ALLOC:   state_d = ST_ALLOC;
            OP_GROW:    state_d = ST_GROW_PRE;
            default:    state_d = ST_NOP;
          endcase
        end
      end
      ST_SWEEP: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_ALLOC: begin
        if (sts_i.hit || sts_i.scan_idle) state_d = ST_IDLE;
      end
      ST_GROW_PRE: begin
        state_d = sts_i.pre_fail ? ST_IDLE : ST_GROW_CHK;
      end
      ST_GROW_CHK: begin
        if (sts_i.bad) begin
          state_d = ST_IDLE;
        end else if (sts_i.scan_idle) begin
          state_d = ST_GROW_WR;
        end
      end
      ST_GROW_WR: begin
        if (sts_i.wr_last) state_d = ST_IDLE;
      end
      ST_NOP: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_BOOT: begin
        cmd_o.rebuild_init = 1'b1;
      end
      ST_BOOT_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
      end
      ST_IDLE: begin
        if (start_i) begin
          unique case (op_w)
            OP_REBUILD: cmd_o.rebuild_init = 1'b1;
            OP_ALLOC:   cmd_o.alloc_init   = 1'b1;
            OP_GROW:    cmd_o.grow_init    = 1'b1;
            default:    cmd_o.rebuild_init = 1'b0;
          endcase
        end
      end
      ST_SWEEP: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RK_ZERO;
        end
      end
      ST_ALLOC: begin
        if (sts_i.hit) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RK_ALLOC;
        end else if (sts_i.scan_idle) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RK_FAIL;
        end else begin
          cmd_o.alloc_step = 1'b1;
        end
      end
      ST_GROW_PRE: begin
        cmd_o.grow_pre = 1'b1;
        if (sts_i.pre_fail) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RK_FAIL;
        end
      end
      ST_GROW_CHK: begin
        if (sts_i.bad) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RK_FAIL;
        end else if (sts_i.scan_idle) begin
          cmd_o.wr_init = 1'b1;
        end else begin
          cmd_o.chk_step = 1'b1;
        end
      end
      ST_GROW_WR: begin
        cmd_o.wr_step = 1'b1;
        if (sts_i.wr_last) begin
          cmd_o.finish = 1'b1;
          cmd_o.kind   = RK_GROW;
        end
      end
      ST_NOP: begin
        cmd_o.finish = 1'b1;
        cmd_o.kind   = RK_ZERO;
      end
      default: begin
        cmd_o.finish = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/page_state_map_allocator.sv
// Top level of the page state map allocator: controller, datapath and page state memory.
// Depends on psma_pkg, psma_ctrl, psma_dp and psma_ram.
`timescale 1ns / 1ps

// Usage
//   Command channel: an item (op_i, increment_i) is taken at a rising edge where start is
//   high and busy is low. Op 0 rebuilds the page map, op 1 claims the highest free page
//   below the heap top (page 0 is never handed out), op 2 grows the break by increment_i
//   bytes, and op 3 does nothing. Every item produces exactly one result beat.
//   Result channel: done_o is high for one cycle with status_o, page_index_o and
//   byte_offset_o. The receiver cannot stall it; busy is already low in that cycle, so
//   the next command may be issued right away.
//   Configuration channel: cfg_data_i is written to the heap page count whenever
//   cfg_valid_i is high (cfg_ready_o is always high). It takes effect at the next rebuild.
// Operation
//   The page map lives in a RAM with a registered read, so every walk moves one page per
//   cycle. An allocation inspects pages from the top down and ends at the first free
//   page, or fails when no page is free. A grow that fails its size or heap-end test
//   ends without a walk. Otherwise the pages of the range are checked one per cycle, and
//   the grow fails at the first taken page; if all are usable a second pass marks them.
// Reset
//   After reset the block sweeps every RAM entry to build the map for 1024 heap pages
//   (or NUM_PAGES if smaller); busy stays high while it does so, and no beat is given.

module page_state_map_allocator
  import psma_pkg::*;
#(
  parameter int unsigned NUM_PAGES  = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [OP_W-1:0]       op_i,
  input  logic [INC_W-1:0]      increment_i,
  output logic                  done_o,
  output logic                  status_o,
  output logic [PAGE_IDX_W-1:0] page_index_o,
  output logic [OFFSET_W-1:0]   byte_offset_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [HP_W-1:0]       cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The count register is only sampled at a rebuild, so writes are always welcome.
  assign cfg_ready_o = 1'b1;

  psma_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  psma_dp #(
    .NUM_PAGES (NUM_PAGES),
    .PAGE_BYTES(PAGE_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .increment_i  (increment_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .page_index_o (page_index_o),
    .byte_offset_o(byte_offset_o)
  );

endmodule

### rtl/psma_checker.sv
// Port-level checker for the page state map allocator and its bind to the top level.
// Depends on psma_pkg for field widths.
`timescale 1ns / 1ps

module psma_checker
  import psma_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  start,
  input logic                  busy,
  input logic                  done_o,
  input logic                  status_o,
  input logic [PAGE_IDX_W-1:0] page_index_o,
  input logic [OFFSET_W-1:0]   byte_offset_o
);

  // An accepted command always makes the block busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // A result beat only ends a busy period.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("result beat without a preceding busy period");

  // One beat per command: never two result cycles in a row.
  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for more than one cycle");

  // An out-of-memory report carries no page or offset.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> ((page_index_o == '0) && (byte_offset_o == '0)))
    else $error("failed result carries nonzero fields");

endmodule

bind page_state_map_allocator psma_checker u_psma_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .status_o     (status_o),
  .page_index_o (page_index_o),
  .byte_offset_o(byte_offset_o)
);
